// ===== rtl/pps_pkg.sv =====
// Package: sizes, table entry type, controller states, command codes and saturation helper for the scheduler.
package pps_pkg;

	localparam int MAX_JOBS  = 16;
	localparam int TIME_BITS = 16;
	localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int SLOT_W    = 4;
	localparam int PRIO_W    = 8;
	localparam int FIELD_W   = 16;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] orig;
		logic [FIELD_W-1:0] remaining;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	function automatic logic [FIELD_W-1:0] sat16(input logic [TIME_BITS-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		if (wide > 32'(16'hFFFF))
			return 16'hFFFF;
		else
			return FIELD_W'(wide);
	endfunction

endpackage

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Top level: preemptive priority scheduler with job table in a synchronous memory.
//
// channel | signals                                                  | transaction
// --------+----------------------------------------------------------+---------------------------
// input   | start, busy, command, job_slot, job_priority,            | start && !busy at clk edge
//         | job_arrival, job_burst                                   |
// result  | done, ran_job, served_slot, job_finished, finish_time,   | done high for one cycle
//         | turnaround, wait_time                                    |
//
// A load writes the slot at the accepting edge.
// A tick holds busy while the table is read one slot at a time through the single read port,
// the last compare is made in the drain state and write-back in the update state; the result
// strobe follows in the next cycle, where a new transaction can be taken.
// Reset clears the loaded flags and time; table contents stay undefined until loaded.
// The receiver cannot stall; done is one cycle wide.
module preemptive_priority_scheduler_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [pps_pkg::SLOT_W-1:0] job_slot,
	input  logic [pps_pkg::PRIO_W-1:0] job_priority,
	input  logic [pps_pkg::FIELD_W-1:0] job_arrival,
	input  logic [pps_pkg::FIELD_W-1:0] job_burst,
	output logic                       done,
	output logic                       ran_job,
	output logic [pps_pkg::SLOT_W-1:0] served_slot,
	output logic                       job_finished,
	output logic [pps_pkg::FIELD_W-1:0] finish_time,
	output logic [pps_pkg::FIELD_W-1:0] turnaround,
	output logic [pps_pkg::FIELD_W-1:0] wait_time
);

	localparam logic [pps_pkg::IDX_W-1:0] LAST_IDX = pps_pkg::IDX_W'(pps_pkg::MAX_JOBS - 1);
	localparam logic [pps_pkg::TIME_BITS-1:0] TIME_MAX = '1;

	pps_pkg::entry_t mem [pps_pkg::MAX_JOBS];

	pps_pkg::state_t state_q, state_d;

	logic                           accept;
	logic                           load_we;
	logic                           scan_re;
	logic                           scan_start;
	logic                           upd_we;
	logic                           report;

	logic [pps_pkg::IDX_W-1:0]      scan_q;
	logic [pps_pkg::IDX_W-1:0]      idx_s1;
	logic                           rvalid_s1;
	pps_pkg::entry_t                rdata_s1;

	logic [pps_pkg::MAX_JOBS-1:0]   loaded_q;
	logic [pps_pkg::TIME_BITS-1:0]  time_q;
	logic [pps_pkg::TIME_BITS-1:0]  time_next;

	logic                           found_q;
	logic [pps_pkg::IDX_W-1:0]      best_idx_q;
	pps_pkg::entry_t                best_q;

	logic                           elig;
	logic                           better;

	logic                           mem_we;
	logic [pps_pkg::IDX_W-1:0]      mem_waddr;
	pps_pkg::entry_t                mem_wdata;

	logic                           ran_q;
	logic [pps_pkg::SLOT_W-1:0]     slot_q;
	logic                           fin_q;
	logic [pps_pkg::TIME_BITS-1:0]  tat_q;
	logic [pps_pkg::FIELD_W-1:0]    orig_q;
	logic [pps_pkg::TIME_BITS-1:0]  tat_d;
	logic [31:0]                    wt_wide;
	logic                           slot_ok;

	assign accept  = start && !busy;
	assign slot_ok = 32'(job_slot) < 32'(pps_pkg::MAX_JOBS);
	assign load_we = accept && (command == pps_pkg::CMD_LOAD) && slot_ok;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (accept && command == pps_pkg::CMD_TICK)
					state_d = pps_pkg::ST_SCAN;
			end
			pps_pkg::ST_SCAN: begin
				if (scan_q == LAST_IDX)
					state_d = pps_pkg::ST_DRAIN;
			end
			pps_pkg::ST_DRAIN: begin
				state_d = pps_pkg::ST_UPDATE;
			end
			pps_pkg::ST_UPDATE: begin
				state_d = pps_pkg::ST_IDLE;
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		scan_re    = 1'b0;
		upd_we     = 1'b0;
		scan_start = 1'b0;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				busy       = 1'b0;
				scan_start = accept && command == pps_pkg::CMD_TICK;
			end
			pps_pkg::ST_SCAN: begin
				scan_re = 1'b1;
			end
			pps_pkg::ST_DRAIN: begin
				busy = 1'b1;
			end
			pps_pkg::ST_UPDATE: begin
				upd_we = found_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table port: one write, one registered read
	always_comb begin
		mem_we    = load_we || upd_we;
		mem_waddr = best_idx_q;
		mem_wdata = best_q;
		mem_wdata.remaining = best_q.remaining - 16'd1;
		if (load_we) begin
			mem_waddr           = pps_pkg::IDX_W'(job_slot);
			mem_wdata.prio      = job_priority;
			mem_wdata.arrival   = job_arrival;
			mem_wdata.orig      = job_burst;
			mem_wdata.remaining = job_burst;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (scan_re) begin
			rdata_s1 <= mem[scan_q];
			idx_s1   <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= scan_re;
			if (scan_start)
				scan_q <= '0;
			else if (scan_re && scan_q != LAST_IDX)
				scan_q <= scan_q + 1'b1;
		end
	end

	// select best eligible entry
	assign elig = loaded_q[idx_s1] && (rdata_s1.remaining != '0) &&
	              (32'(rdata_s1.arrival) <= 32'(time_q));
	assign better = !found_q || (rdata_s1.prio < best_q.prio) ||
	                ((rdata_s1.prio == best_q.prio) && (rdata_s1.arrival < best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (scan_start) begin
			found_q <= 1'b0;
		end else if (rvalid_s1 && elig && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rvalid_s1 && elig && better) begin
			best_idx_q <= idx_s1;
			best_q     <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (load_we) begin
			loaded_q[pps_pkg::IDX_W'(job_slot)] <= 1'b1;
		end
	end

	// advance time, saturate at maximum
	assign time_next = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
	assign tat_d     = time_next - pps_pkg::TIME_BITS'(32'(best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			report <= 1'b0;
		end else begin
			report <= (state_q == pps_pkg::ST_UPDATE);
			if (state_q == pps_pkg::ST_UPDATE)
				time_q <= time_next;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::ST_UPDATE) begin
			ran_q  <= found_q;
			slot_q <= found_q ? pps_pkg::SLOT_W'(best_idx_q) : '0;
			fin_q  <= found_q && (best_q.remaining == 16'd1);
			tat_q  <= tat_d;
			orig_q <= best_q.orig;
		end
	end

	assign wt_wide = (32'(tat_q) > 32'(orig_q)) ? (32'(tat_q) - 32'(orig_q)) : 32'd0;

	assign done         = report;
	assign ran_job      = ran_q;
	assign served_slot  = slot_q;
	assign job_finished = fin_q;
	assign finish_time  = pps_pkg::sat16(time_q);
	assign turnaround   = fin_q ? pps_pkg::sat16(tat_q) : '0;
	assign wait_time    = fin_q ? ((wt_wide > 32'(16'hFFFF)) ? 16'hFFFF
	                                 : pps_pkg::FIELD_W'(wt_wide)) : '0;

endmodule

// ===== rtl/pps_checker.sv =====
// Checker: port-level properties of the scheduler core, bound to the top level.
module pps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic                        done,
	input logic                        ran_job,
	input logic                        job_finished,
	input logic [pps_pkg::FIELD_W-1:0] turnaround,
	input logic [pps_pkg::FIELD_W-1:0] wait_time
);

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == pps_pkg::CMD_TICK) |=> busy)
		else $error("tick transaction did not raise busy");

	a_fell_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(done && job_finished) |-> ran_job)
		else $error("completion reported on an idle tick");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !job_finished) |-> (turnaround == '0 && wait_time == '0))
		else $error("nonzero turnaround or wait without completion");

endmodule

bind preemptive_priority_scheduler_core pps_checker u_pps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.done         (done),
	.ran_job      (ran_job),
	.job_finished (job_finished),
	.turnaround   (turnaround),
	.wait_time    (wait_time)
);
